// ===== hw/rtl/tcm_pkg.sv =====
// Shared types, constants and the divider step for the touch calibration mapper.
// Used by tcm_lane, tcm_merge and touch_calibration_mapper_unit.
package tcm_pkg;

  // Widths
  localparam int AdcBits     = 12;
  localparam int SizeBits    = 12;
  localparam int ProdBits    = AdcBits + SizeBits;
  localparam int FlagBits    = 3;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = (AdcBits > SizeBits) ? AdcBits : SizeBits;
  localparam int InDataBits  = ((2 * AdcBits + 7) / 8) * 8;
  localparam int OutDataBits = ((2 * SizeBits + 7) / 8) * 8;

  // Lane pipeline depth: window stage, multiply stage, one stage per quotient bit
  localparam int LaneDepth = 2 + SizeBits;

  // Register indexes
  localparam logic [CfgIdxBits-1:0] RegXLow   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegXHigh  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegYLow   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegYHigh  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegOrient = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegWidth  = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegHeight = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegMinLvl = 3'd7;

  // Orientation bits
  localparam int FlagInvX = 0;
  localparam int FlagInvY = 1;
  localparam int FlagSwap = 2;

  // Reset values
  localparam logic [AdcBits-1:0]  ResetXLow   = '0;
  localparam logic [AdcBits-1:0]  ResetXHigh  = '1;
  localparam logic [AdcBits-1:0]  ResetYLow   = '0;
  localparam logic [AdcBits-1:0]  ResetYHigh  = '1;
  localparam logic [FlagBits-1:0] ResetOrient = '0;
  localparam logic [SizeBits-1:0] ResetWidth  = SizeBits'(320);
  localparam logic [SizeBits-1:0] ResetHeight = SizeBits'(240);
  localparam logic [AdcBits-1:0]  ResetMinLvl = AdcBits'(100);

  // Per-lane axis setup
  typedef struct packed {
    logic [AdcBits-1:0]  lo;
    logic [AdcBits-1:0]  hi;
    logic                inv;
    logic [SizeBits-1:0] size;
  } lane_cfg_t;

  // Divider state: partial remainder, dividend bits still to go merged with
  // quotient bits already found, and the divisor
  typedef struct packed {
    logic [AdcBits-1:0]  rem;
    logic [SizeBits-1:0] lq;
    logic [AdcBits-1:0]  den;
  } div_state_t;

  // One result item
  typedef struct packed {
    logic                touched;
    logic                cal_err;
    logic [SizeBits-1:0] sx;
    logic [SizeBits-1:0] sy;
  } out_item_t;

  // Sideband carried beside the lanes
  typedef struct packed {
    logic touched;
    logic cal_err;
  } side_t;

  // One restoring-division step: bring in the next dividend bit, subtract if it fits
  function automatic div_state_t div_step(input div_state_t s);
    logic [AdcBits:0]   t;
    logic [AdcBits:0]   d;
    logic [AdcBits:0]   diff;
    logic               ge;
    div_state_t         r;
    t    = {s.rem, s.lq[SizeBits-1]};
    d    = {1'b0, s.den};
    diff = t - d;
    ge   = (t >= d);
    r.rem = ge ? diff[AdcBits-1:0] : t[AdcBits-1:0];
    r.lq  = {s.lq[SizeBits-2:0], ge};
    r.den = s.den;
    return r;
  endfunction

endpackage

// ===== hw/rtl/tcm_lane.sv =====
// One axis lane: clamp to the window, scale by the screen size, divide by the window span.
// Depends on tcm_pkg (lane_cfg_t, div_state_t, div_step).
module tcm_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic [tcm_pkg::AdcBits-1:0]  raw,
  input  tcm_pkg::lane_cfg_t           cfg,
  output logic [tcm_pkg::SizeBits-1:0] quot
);

  logic                         bad;
  logic [tcm_pkg::AdcBits-1:0]  clamped;
  logic [tcm_pkg::AdcBits-1:0]  num_d;
  logic [tcm_pkg::AdcBits-1:0]  den_d;

  logic [tcm_pkg::AdcBits-1:0]  num;
  logic [tcm_pkg::AdcBits-1:0]  den;
  logic [tcm_pkg::SizeBits-1:0] size;

  logic [tcm_pkg::ProdBits-1:0] prod;
  logic [tcm_pkg::AdcBits-1:0]  prod_den;

  tcm_pkg::div_state_t          div_in [1:tcm_pkg::SizeBits];
  tcm_pkg::div_state_t          div_st [1:tcm_pkg::SizeBits];

  // Clamp and form numerator and span; an empty window divides zero by one
  always_comb begin
    bad = (cfg.hi <= cfg.lo);
    if (raw < cfg.lo) begin
      clamped = cfg.lo;
    end else if (raw > cfg.hi) begin
      clamped = cfg.hi;
    end else begin
      clamped = raw;
    end
    if (bad) begin
      num_d = '0;
      den_d = tcm_pkg::AdcBits'(1);
    end else begin
      num_d = cfg.inv ? (cfg.hi - clamped) : (clamped - cfg.lo);
      den_d = cfg.hi - cfg.lo;
    end
  end

  // Window stage and multiply stage
  always_ff @(posedge clk) begin
    if (en) begin
      num      <= num_d;
      den      <= den_d;
      size     <= cfg.size;
      prod     <= tcm_pkg::ProdBits'(num) * tcm_pkg::ProdBits'(size);
      prod_den <= den;
    end
  end

  // Divider stages: product high half is below the span, so one quotient bit per stage
  assign div_in[1] = tcm_pkg::div_step(tcm_pkg::div_state_t'{
    rem: prod[tcm_pkg::ProdBits-1:tcm_pkg::SizeBits],
    lq:  prod[tcm_pkg::SizeBits-1:0],
    den: prod_den
  });

  for (genvar k = 2; k <= tcm_pkg::SizeBits; k++) begin : g_div
    assign div_in[k] = tcm_pkg::div_step(div_st[k-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= tcm_pkg::SizeBits; k++) begin
        div_st[k] <= div_in[k];
      end
    end
  end

  assign quot = div_st[tcm_pkg::SizeBits].lq;

endmodule

// ===== hw/rtl/tcm_merge.sv =====
// Merge stage: combine both lane quotients with the sideband into one result beat,
// held in an output register backed by a skid register. Depends on tcm_pkg.
module tcm_merge (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  tcm_pkg::side_t                  in_side,
  input  logic [tcm_pkg::SizeBits-1:0]    quot_x,
  input  logic [tcm_pkg::SizeBits-1:0]    quot_y,
  output logic                            pipe_ready,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tcm_pkg::OutDataBits-1:0] m_axis_tdata,  // screen_x, screen_y
  output logic [1:0]                      m_axis_tuser   // touched, calibration_error
);

  tcm_pkg::out_item_t in_item;
  tcm_pkg::out_item_t out_item;
  tcm_pkg::out_item_t skid_item;
  logic               out_valid;
  logic               skid_valid;
  logic               take_in;
  logic               out_free;

  // Zero the coordinates of a sample that is not a touch
  always_comb begin
    in_item.touched = in_side.touched;
    in_item.cal_err = in_side.cal_err;
    in_item.sx      = in_side.touched ? quot_x : '0;
    in_item.sy      = in_side.touched ? quot_y : '0;
  end

  assign pipe_ready = !skid_valid;
  assign take_in    = in_valid && pipe_ready;
  assign out_free   = !out_valid || m_axis_tready;

  // Output register with skid; the skid drains first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_item   <= skid_item;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (take_in) begin
        out_item  <= in_item;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (take_in) begin
      skid_item  <= in_item;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = tcm_pkg::OutDataBits'({out_item.sy, out_item.sx});
  assign m_axis_tuser  = {out_item.cal_err, out_item.touched};

  // A held skid beat always sits behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output register is empty");

  // Skid moves into the output register when the receiver takes a beat
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && m_axis_tready |=> out_valid && !skid_valid)
    else $error("skid beat lost on drain");

  // No touch means zero coordinates
  a_zero_untouched: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.touched |-> out_item.sx == '0 && out_item.sy == '0)
    else $error("untouched beat carries coordinates");

endmodule

// ===== hw/rtl/touch_calibration_mapper_unit.sv =====
// Top level of the touch calibration mapper: configuration registers, input decode,
// two axis lanes and the merge stage. Depends on tcm_pkg, tcm_lane, tcm_merge.
//
// Usage:
//  - Input beats on s_axis: pen_down in tuser, raw_x and raw_y in tdata.
//  - Result beats on m_axis: screen_x and screen_y in tdata, touched and
//    calibration_error in tuser. Exactly one result beat per input beat, in order.
//  - Registers are written through cfg_we/cfg_index/cfg_data, one per cycle; the block
//    leaves it to the user to write them only while no sample is in flight.
//  - Throughput: one sample per cycle while the pipeline is not frozen. Each axis runs in its own lane: a window
//    stage, a 12x12 multiply stage and a 12-stage restoring divider that yields
//    one quotient bit per stage.
//  - Path: the accepting edge loads the first of 14 lane stages; the output
//    register follows the last and drives m_axis_tvalid.
//  - Stall: when the receiver holds m_axis_tready low, one more beat lands in a
//    skid register; s_axis_tready then drops and the whole lane pipeline freezes.
//    s_axis_tready comes from a register only.
//  - Reset (rst, synchronous): registers return to their defaults (full window,
//    no inversion or swap, 320x240 screen, minimum level 100) and all in-flight
//    beats are dropped.
module touch_calibration_mapper_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tcm_pkg::InDataBits-1:0]    s_axis_tdata,  // raw_x, raw_y
  input  logic                              s_axis_tuser,  // pen_down
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tcm_pkg::OutDataBits-1:0]   m_axis_tdata,  // screen_x, screen_y
  output logic [1:0]                        m_axis_tuser,  // touched, calibration_error
  input  logic                              cfg_we,
  input  logic [tcm_pkg::CfgIdxBits-1:0]    cfg_index,
  input  logic [tcm_pkg::CfgDataBits-1:0]   cfg_data
);

  logic [tcm_pkg::AdcBits-1:0]  x_window_low;
  logic [tcm_pkg::AdcBits-1:0]  x_window_high;
  logic [tcm_pkg::AdcBits-1:0]  y_window_low;
  logic [tcm_pkg::AdcBits-1:0]  y_window_high;
  logic [tcm_pkg::FlagBits-1:0] orientation_flags;
  logic [tcm_pkg::SizeBits-1:0] screen_width;
  logic [tcm_pkg::SizeBits-1:0] screen_height;
  logic [tcm_pkg::AdcBits-1:0]  min_valid_level;

  logic                         en;
  logic                         accept;
  logic [tcm_pkg::AdcBits-1:0]  raw_x;
  logic [tcm_pkg::AdcBits-1:0]  raw_y;
  logic                         swap;
  tcm_pkg::lane_cfg_t           x_axis_cfg;
  tcm_pkg::lane_cfg_t           y_axis_cfg;
  tcm_pkg::lane_cfg_t           lane0_cfg;
  tcm_pkg::lane_cfg_t           lane1_cfg;
  logic [tcm_pkg::AdcBits-1:0]  lane0_raw;
  logic [tcm_pkg::AdcBits-1:0]  lane1_raw;
  logic [tcm_pkg::SizeBits-1:0] quot_x;
  logic [tcm_pkg::SizeBits-1:0] quot_y;
  tcm_pkg::side_t               side_d;

  logic                         vld  [1:tcm_pkg::LaneDepth];
  tcm_pkg::side_t               side [1:tcm_pkg::LaneDepth];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_window_low      <= tcm_pkg::ResetXLow;
      x_window_high     <= tcm_pkg::ResetXHigh;
      y_window_low      <= tcm_pkg::ResetYLow;
      y_window_high     <= tcm_pkg::ResetYHigh;
      orientation_flags <= tcm_pkg::ResetOrient;
      screen_width      <= tcm_pkg::ResetWidth;
      screen_height     <= tcm_pkg::ResetHeight;
      min_valid_level   <= tcm_pkg::ResetMinLvl;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcm_pkg::RegXLow:   x_window_low      <= cfg_data[tcm_pkg::AdcBits-1:0];
        tcm_pkg::RegXHigh:  x_window_high     <= cfg_data[tcm_pkg::AdcBits-1:0];
        tcm_pkg::RegYLow:   y_window_low      <= cfg_data[tcm_pkg::AdcBits-1:0];
        tcm_pkg::RegYHigh:  y_window_high     <= cfg_data[tcm_pkg::AdcBits-1:0];
        tcm_pkg::RegOrient: orientation_flags <= cfg_data[tcm_pkg::FlagBits-1:0];
        tcm_pkg::RegWidth:  screen_width      <= cfg_data[tcm_pkg::SizeBits-1:0];
        tcm_pkg::RegHeight: screen_height     <= cfg_data[tcm_pkg::SizeBits-1:0];
        tcm_pkg::RegMinLvl: min_valid_level   <= cfg_data[tcm_pkg::AdcBits-1:0];
        default: ;
      endcase
    end
  end

  // Decode the input beat and route axes to lanes; lane 0 feeds screen_x
  always_comb begin
    raw_x = s_axis_tdata[tcm_pkg::AdcBits-1:0];
    raw_y = s_axis_tdata[2*tcm_pkg::AdcBits-1:tcm_pkg::AdcBits];
    swap  = orientation_flags[tcm_pkg::FlagSwap];

    x_axis_cfg.lo  = x_window_low;
    x_axis_cfg.hi  = x_window_high;
    x_axis_cfg.inv = orientation_flags[tcm_pkg::FlagInvX];
    y_axis_cfg.lo  = y_window_low;
    y_axis_cfg.hi  = y_window_high;
    y_axis_cfg.inv = orientation_flags[tcm_pkg::FlagInvY];
    x_axis_cfg.size = '0;
    y_axis_cfg.size = '0;

    lane0_cfg      = swap ? y_axis_cfg : x_axis_cfg;
    lane1_cfg      = swap ? x_axis_cfg : y_axis_cfg;
    lane0_cfg.size = screen_width;
    lane1_cfg.size = screen_height;
    lane0_raw      = swap ? raw_y : raw_x;
    lane1_raw      = swap ? raw_x : raw_y;

    side_d.touched = s_axis_tuser && (raw_x >= min_valid_level)
                     && (raw_y >= min_valid_level);
    side_d.cal_err = (x_window_high <= x_window_low) || (y_window_high <= y_window_low);
  end

  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tcm_lane u_lane0 (
    .clk  (clk),
    .en   (en),
    .raw  (lane0_raw),
    .cfg  (lane0_cfg),
    .quot (quot_x)
  );

  tcm_lane u_lane1 (
    .clk  (clk),
    .en   (en),
    .raw  (lane1_raw),
    .cfg  (lane1_cfg),
    .quot (quot_y)
  );

  // Carry beat valid and sideband alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= tcm_pkg::LaneDepth; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= accept;
      for (int k = 2; k <= tcm_pkg::LaneDepth; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[1] <= side_d;
      for (int k = 2; k <= tcm_pkg::LaneDepth; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  tcm_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (vld[tcm_pkg::LaneDepth]),
    .in_side       (side[tcm_pkg::LaneDepth]),
    .quot_x        (quot_x),
    .quot_y        (quot_y),
    .pipe_ready    (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // A frozen pipeline keeps its last-stage beat
  a_hold_on_freeze: assert property (@(posedge clk) disable iff (rst)
    !en && vld[tcm_pkg::LaneDepth] |=> vld[tcm_pkg::LaneDepth])
    else $error("last lane stage dropped a beat while frozen");

  // An accepted beat enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> vld[1])
    else $error("accepted beat missing from first lane stage");

  // The reported error flag follows the windows
  a_cal_err_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !cfg_we && (x_window_high <= x_window_low) |-> m_axis_tuser[1])
    else $error("empty X window without calibration error");

endmodule
